@@ hw/rtl/jpeg_exif_segment_locator_macros.svh @@
// assertion macros used by the exif segment locator top level
`ifndef JPEG_EXIF_SEGMENT_LOCATOR_MACROS_SVH
`define JPEG_EXIF_SEGMENT_LOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define JESL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define JESL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/jesl_pkg.sv @@
// types, codes and constants of the jpeg exif segment locator
`default_nettype none

package jesl_pkg;

  localparam int OFFSET_WIDTH_DEF = 32;
  localparam int PAYLOAD_OFFSET_W = 32;
  localparam int PAYLOAD_SIZE_W   = 16;

  // marker bytes
  localparam logic [7:0] MK_PREFIX = 8'hff;
  localparam logic [7:0] MK_SOI    = 8'hd8;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_RST0   = 8'hd0;
  localparam logic [7:0] MK_RST7   = 8'hd7;
  localparam logic [7:0] MK_SOS    = 8'hda;
  localparam logic [7:0] MK_EOI    = 8'hd9;
  localparam logic [7:0] MK_APP1   = 8'he1;

  localparam logic [2:0]  SIG_LEN       = 3'd6;
  localparam logic [2:0]  SIG_NONE      = 3'd7;
  localparam logic [15:0] SEG_LEN_MIN   = 16'd2;
  localparam int          MIN_FOUND_SZ  = 8;
  // index of the twelfth byte: a verdict is held back until it is reached
  localparam int          SHORT_LAST_IDX = 11;

  typedef enum logic [7:0] {
    PH_SOI0  = 8'b0000_0001,
    PH_SOI1  = 8'b0000_0010,
    PH_MFF   = 8'b0000_0100,
    PH_MCODE = 8'b0000_1000,
    PH_LENH  = 8'b0001_0000,
    PH_LENL  = 8'b0010_0000,
    PH_BODY  = 8'b0100_0000,
    PH_DONE  = 8'b1000_0000
  } jesl_phase_t;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_NO_EXIF  = 2'd1,
    ST_NOT_JPEG = 2'd2,
    ST_SHORT    = 2'd3
  } jesl_status_t;

  typedef struct packed {
    jesl_status_t                  status;
    logic [PAYLOAD_OFFSET_W-1:0]   payload_offset;
    logic [PAYLOAD_SIZE_W-1:0]     payload_size;
  } jesl_result_t;

  typedef struct packed {
    jesl_phase_t phase;
    logic        result_sent;
  } jesl_core_stat_t;

  // "Exif" followed by two zero bytes
  function automatic logic [7:0] exif_sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h45;
      3'd1:    b = 8'h78;
      3'd2:    b = 8'h69;
      3'd3:    b = 8'h66;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/jesl_in_if.sv @@
// byte stream channel into the exif segment locator
`default_nettype none

interface jesl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/jesl_out_if.sv @@
// result channel out of the exif segment locator
`default_nettype none

interface jesl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            status;
  logic [jesl_pkg::PAYLOAD_OFFSET_W-1:0] payload_offset;
  logic [jesl_pkg::PAYLOAD_SIZE_W-1:0]   payload_size;

  modport source(output valid, output status, output payload_offset,
                 output payload_size, input ready);
  modport sink(input valid, input status, input payload_offset,
               input payload_size, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/jesl_in_stage.sv @@
// input register holding one accepted byte for the parser
`default_nettype none

module jesl_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  input  wire logic       advance,
  output logic            s1_valid,
  output logic [7:0]      s1_byte,
  output logic            s1_last
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       take;

  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;
  assign s1_last  = last_r;

endmodule

`default_nettype wire

@@ hw/rtl/jesl_parse_core.sv @@
// marker segment walker: parse state, exif match and verdict per byte
`default_nettype none

module jesl_parse_core #(
  parameter int OFFSET_WIDTH = jesl_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  output logic                      emit,
  output jesl_pkg::jesl_result_t    result,
  output jesl_pkg::jesl_core_stat_t stat
);

  localparam int PW = OFFSET_WIDTH + 1;

  logic [OFFSET_WIDTH-1:0] pos_r, pos_nxt;
  jesl_pkg::jesl_phase_t   phase_r, phase_nxt;
  logic [7:0]              marker_r, marker_nxt;
  logic [7:0]              len_hi_r, len_hi_nxt;
  logic [15:0]             remain_r, remain_nxt;
  logic [2:0]              sig_idx_r, sig_idx_nxt;
  logic                    found_r, found_nxt;
  logic                    sent_r, sent_nxt;
  logic [PW-1:0]           pstart_r, pstart_nxt;
  jesl_pkg::jesl_status_t  verdict_r, verdict_nxt;

  logic [PW-1:0]           pos_p1;
  logic [PW-1:0]           size;
  logic [15:0]             seg_len;
  logic [15:0]             seg_body;
  logic [15:0]             remain_dec;
  logic                    standalone;
  logic                    past_short;
  jesl_pkg::jesl_status_t  st;

  assign pos_p1     = PW'(pos_r) + PW'(1);
  assign size       = pos_p1 - pstart_r;
  assign seg_len    = {len_hi_r, data_byte};
  assign seg_body   = seg_len - jesl_pkg::SEG_LEN_MIN;
  assign remain_dec = remain_r - 16'd1;
  assign past_short = pos_r >= OFFSET_WIDTH'(jesl_pkg::SHORT_LAST_IDX);
  assign standalone = (data_byte == jesl_pkg::MK_SOI) || (data_byte == jesl_pkg::MK_TEM) ||
                      ((data_byte >= jesl_pkg::MK_RST0) && (data_byte <= jesl_pkg::MK_RST7));

  // consume one byte
  always_comb begin
    phase_nxt   = phase_r;
    marker_nxt  = marker_r;
    len_hi_nxt  = len_hi_r;
    remain_nxt  = remain_r;
    sig_idx_nxt = sig_idx_r;
    found_nxt   = found_r;
    pstart_nxt  = pstart_r;
    verdict_nxt = verdict_r;
    if (!sent_r) begin
      unique case (phase_r)
        jesl_pkg::PH_SOI0: begin
          if (data_byte == jesl_pkg::MK_PREFIX) begin
            phase_nxt = jesl_pkg::PH_SOI1;
          end else begin
            phase_nxt   = jesl_pkg::PH_DONE;
            verdict_nxt = jesl_pkg::ST_NOT_JPEG;
          end
        end
        jesl_pkg::PH_SOI1: begin
          if (data_byte == jesl_pkg::MK_SOI) begin
            phase_nxt = jesl_pkg::PH_MFF;
          end else begin
            phase_nxt   = jesl_pkg::PH_DONE;
            verdict_nxt = jesl_pkg::ST_NOT_JPEG;
          end
        end
        jesl_pkg::PH_MFF: begin
          if (data_byte == jesl_pkg::MK_PREFIX) begin
            phase_nxt = jesl_pkg::PH_MCODE;
          end else begin
            phase_nxt   = jesl_pkg::PH_DONE;
            verdict_nxt = jesl_pkg::ST_NO_EXIF;
          end
        end
        jesl_pkg::PH_MCODE: begin
          marker_nxt = data_byte;
          if (standalone) begin
            phase_nxt = jesl_pkg::PH_MFF;
          end else if ((data_byte == jesl_pkg::MK_SOS) || (data_byte == jesl_pkg::MK_EOI)) begin
            phase_nxt   = jesl_pkg::PH_DONE;
            verdict_nxt = jesl_pkg::ST_NO_EXIF;
          end else begin
            phase_nxt = jesl_pkg::PH_LENH;
          end
        end
        jesl_pkg::PH_LENH: begin
          len_hi_nxt = data_byte;
          phase_nxt  = jesl_pkg::PH_LENL;
        end
        jesl_pkg::PH_LENL: begin
          if (seg_len < jesl_pkg::SEG_LEN_MIN) begin
            phase_nxt   = jesl_pkg::PH_DONE;
            verdict_nxt = jesl_pkg::ST_NO_EXIF;
          end else begin
            remain_nxt  = seg_body;
            sig_idx_nxt = ((marker_r == jesl_pkg::MK_APP1) && (seg_body > 16'(jesl_pkg::SIG_LEN)))
                          ? 3'd0 : jesl_pkg::SIG_NONE;
            found_nxt   = 1'b0;
            phase_nxt   = (seg_body != 16'd0) ? jesl_pkg::PH_BODY : jesl_pkg::PH_MFF;
          end
        end
        jesl_pkg::PH_BODY: begin
          if (sig_idx_r < jesl_pkg::SIG_LEN) begin
            if (data_byte == jesl_pkg::exif_sig_byte(sig_idx_r)) begin
              sig_idx_nxt = sig_idx_r + 3'd1;
              if (sig_idx_r == jesl_pkg::SIG_LEN - 3'd1) begin
                found_nxt  = 1'b1;
                pstart_nxt = pos_p1;
              end
            end else begin
              sig_idx_nxt = jesl_pkg::SIG_NONE;
            end
          end
          remain_nxt = remain_dec;
          if (remain_dec == 16'd0) begin
            // a match completed on this very byte leaves an empty payload
            if (found_nxt && found_r && (size >= PW'(jesl_pkg::MIN_FOUND_SZ))) begin
              remain_nxt  = size[15:0];
              phase_nxt   = jesl_pkg::PH_DONE;
              verdict_nxt = jesl_pkg::ST_FOUND;
            end else if (found_nxt) begin
              phase_nxt   = jesl_pkg::PH_DONE;
              verdict_nxt = jesl_pkg::ST_NO_EXIF;
            end else begin
              phase_nxt = jesl_pkg::PH_MFF;
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // result decision for this byte
  always_comb begin
    emit     = 1'b0;
    sent_nxt = sent_r;
    st       = verdict_nxt;
    if (!sent_r) begin
      if ((phase_nxt == jesl_pkg::PH_DONE) && past_short) begin
        emit     = 1'b1;
        sent_nxt = 1'b1;
      end else if (last_byte) begin
        emit = 1'b1;
        if (!past_short) begin
          st = jesl_pkg::ST_SHORT;
        end else if (phase_nxt != jesl_pkg::PH_DONE) begin
          st = jesl_pkg::ST_NO_EXIF;
        end
      end
    end
    result.status = st;
    if (st == jesl_pkg::ST_FOUND) begin
      result.payload_offset = jesl_pkg::PAYLOAD_OFFSET_W'(pstart_nxt);
      result.payload_size   = remain_nxt;
    end else begin
      result.payload_offset = '0;
      result.payload_size   = '0;
    end
  end

  assign pos_nxt = (pos_r != '1) ? pos_r + OFFSET_WIDTH'(1) : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      pos_r     <= '0;
      phase_r   <= jesl_pkg::PH_SOI0;
      marker_r  <= '0;
      len_hi_r  <= '0;
      remain_r  <= '0;
      sig_idx_r <= '0;
      found_r   <= 1'b0;
      sent_r    <= 1'b0;
      pstart_r  <= '0;
      verdict_r <= jesl_pkg::ST_FOUND;
    end else if (step) begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      marker_r  <= marker_nxt;
      len_hi_r  <= len_hi_nxt;
      remain_r  <= remain_nxt;
      sig_idx_r <= sig_idx_nxt;
      found_r   <= found_nxt;
      sent_r    <= sent_nxt;
      pstart_r  <= pstart_nxt;
      verdict_r <= verdict_nxt;
    end
  end

  assign stat.phase       = phase_r;
  assign stat.result_sent = sent_r;

endmodule

`default_nettype wire

@@ hw/rtl/jesl_out_stage.sv @@
// output register holding one result until the sink takes it
`default_nettype none

module jesl_out_stage (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire jesl_pkg::jesl_result_t load_data,
  output logic                       space,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output jesl_pkg::jesl_result_t     out_data
);

  logic                   valid_r, valid_nxt;
  jesl_pkg::jesl_result_t data_r;

  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ hw/rtl/jpeg_exif_segment_locator.sv @@
// top level of the jpeg exif segment locator
// path: an accepted byte sits in the input register; its result goes to the output register
// throughput: one byte per cycle; the input register keeps taking bytes while a
//   result waits, as long as that byte decides no new result
// reset: synchronous active-low rst_n clears both handshake stages and the parse
//   state; the final byte of a file returns the parse state to its reset value
`default_nettype none
`include "jpeg_exif_segment_locator_macros.svh"

module jpeg_exif_segment_locator #(
  parameter int OFFSET_WIDTH = jesl_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jesl_in_if.sink    in_if,
  jesl_out_if.source out_if
);

  // stage 1: registered byte
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_adv;

  // parser outputs for the byte held in stage 1
  logic                      core_emit;
  jesl_pkg::jesl_result_t    core_result;
  jesl_pkg::jesl_core_stat_t core_stat;

  // output register
  logic                   out_space;
  jesl_pkg::jesl_result_t out_data;

  // a byte that decides no result moves on even when the output slot is full
  assign s1_adv = s1_valid && (!core_emit || out_space);

  jesl_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_data_byte (in_if.data_byte),
    .in_last_byte (in_if.last_byte),
    .advance      (s1_adv),
    .s1_valid     (s1_valid),
    .s1_byte      (s1_byte),
    .s1_last      (s1_last)
  );

  // parse state advances only when the stage 1 transaction moves on
  jesl_parse_core #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_parse_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .emit      (core_emit),
    .result    (core_result),
    .stat      (core_stat)
  );

  jesl_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_adv && core_emit),
    .load_data (core_result),
    .space     (out_space),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_data)
  );

  assign out_if.status         = out_data.status;
  assign out_if.payload_offset = out_data.payload_offset;
  assign out_if.payload_size   = out_data.payload_size;

  // only a found verdict carries an offset and a size
  `JESL_ASSERT_NOW(a_zero_unless_found, clk, rst_n,
    out_if.valid && (out_if.status != jesl_pkg::ST_FOUND),
    (out_if.payload_offset == '0) && (out_if.payload_size == '0),
    "payload fields nonzero without an exif verdict")

  // a found payload is never shorter than the minimum
  `JESL_ASSERT_NOW(a_found_min_size, clk, rst_n,
    out_if.valid && (out_if.status == jesl_pkg::ST_FOUND),
    out_if.payload_size >= 16'(jesl_pkg::MIN_FOUND_SZ),
    "exif payload size below minimum")

  // every file that has not yet reported reports on its final byte
  `JESL_ASSERT_NOW(a_last_reports, clk, rst_n,
    s1_adv && s1_last && !core_stat.result_sent,
    core_emit,
    "final byte of a file gave no result")

  // the final byte returns the parser to its start state
  `JESL_ASSERT_NEXT(a_last_restarts, clk, rst_n,
    s1_adv && s1_last,
    !core_stat.result_sent && (core_stat.phase == jesl_pkg::PH_SOI0),
    "parser not restarted after final byte")

endmodule

`default_nettype wire

@@ verif/jpeg_exif_segment_locator_tb.sv @@
// self-checking testbench for the jpeg exif segment locator
`timescale 1ns / 1ps

module jpeg_exif_segment_locator_tb;
  import jesl_pkg::*;

  localparam int POS_W = OFFSET_WIDTH_DEF;

  // signature that opens an exif app1 body, and some ordinary segment markers
  localparam logic [7:0] EXIF_TAG [6] = '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};
  localparam logic [7:0] PLAIN_CODES [6] = '{8'he0, 8'he2, 8'hdb, 8'hc0, 8'hc4, 8'hfe};

  localparam jesl_result_t RES_ANY      = '0;
  localparam jesl_result_t RES_SHORT    = '{ST_SHORT, 32'd0, 16'd0};
  localparam jesl_result_t RES_MIN_EXIF = '{ST_FOUND, 32'd12, 16'd8};

  // one directed byte; want is only meaningful where typed is set
  typedef struct {
    logic [7:0]   data;
    logic         fin;
    logic         typed;
    jesl_result_t want;
  } byte_row_t;

  logic clk = 1'b0;
  logic rst_n;

  jesl_in_if  in_if();
  jesl_out_if out_if();

  jpeg_exif_segment_locator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // locator shadow state, stepped once per accepted input transaction
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] scan_pos;        // index of the next byte, saturating
  jesl_phase_t      scan_phase;
  logic [7:0]       scan_marker;
  logic [7:0]       scan_len_hi;
  logic [15:0]      scan_left;       // body bytes left; payload size once found
  logic [2:0]       scan_sig_idx;    // signature bytes matched, SIG_NONE = no check
  logic             scan_found;
  logic             scan_sent;       // this file already got its result
  logic [POS_W:0]   scan_tiff_start; // index just past the signature
  jesl_status_t     scan_verdict;

  jesl_result_t exif_results_due[$];

  byte_row_t  dir_rows [24];
  logic [7:0] file_q[$];
  int errors;
  int results_seen;
  int status_hits [4];
  int total_bytes;

  task automatic scan_clear();
    scan_pos        = '0;
    scan_phase      = PH_SOI0;
    scan_marker     = '0;
    scan_len_hi     = '0;
    scan_left       = '0;
    scan_sig_idx    = '0;
    scan_found      = 1'b0;
    scan_sent       = 1'b0;
    scan_tiff_start = '0;
    scan_verdict    = ST_FOUND;
  endtask

  task automatic scan_halt(input jesl_status_t st);
    scan_verdict = st;
    scan_phase   = PH_DONE;
  endtask

  function automatic jesl_result_t scan_report(input jesl_status_t st);
    jesl_result_t r;
    r = '0;
    r.status = st;
    if (st == ST_FOUND) begin
      r.payload_offset = scan_tiff_start[PAYLOAD_OFFSET_W-1:0];
      r.payload_size   = scan_left;
    end
    return r;
  endfunction

  // advance the shadow parser by one byte; fire says whether a result is due
  task automatic scan_byte(input logic [7:0] b, input logic fin,
                           output logic fire, output jesl_result_t res);
    logic [POS_W-1:0] idx;
    logic [15:0]      seg_len;
    logic [POS_W:0]   tail;
    idx  = scan_pos;
    fire = 1'b0;
    res  = '0;
    if (!scan_sent) begin
      case (scan_phase)
        PH_SOI0: begin
          if (b == MK_PREFIX) scan_phase = PH_SOI1;
          else scan_halt(ST_NOT_JPEG);
        end
        PH_SOI1: begin
          if (b == MK_SOI) scan_phase = PH_MFF;
          else scan_halt(ST_NOT_JPEG);
        end
        PH_MFF: begin
          if (b == MK_PREFIX) scan_phase = PH_MCODE;
          else scan_halt(ST_NO_EXIF);
        end
        PH_MCODE: begin
          scan_marker = b;
          // standalone markers carry no length
          if (b == MK_SOI || b == MK_TEM || (b >= MK_RST0 && b <= MK_RST7)) begin
            scan_phase = PH_MFF;
          end else if (b == MK_SOS || b == MK_EOI) begin
            scan_halt(ST_NO_EXIF);
          end else begin
            scan_phase = PH_LENH;
          end
        end
        PH_LENH: begin
          scan_len_hi = b;
          scan_phase  = PH_LENL;
        end
        PH_LENL: begin
          seg_len = {scan_len_hi, b};
          if (seg_len < SEG_LEN_MIN) begin
            scan_halt(ST_NO_EXIF);
          end else begin
            scan_left    = seg_len - SEG_LEN_MIN;
            // only an app1 body longer than the signature is searched
            scan_sig_idx = (scan_marker == MK_APP1 && scan_left > 16'd6) ? 3'd0 : SIG_NONE;
            scan_found   = 1'b0;
            scan_phase   = (scan_left != 16'd0) ? PH_BODY : PH_MFF;
          end
        end
        PH_BODY: begin
          if (scan_sig_idx < SIG_LEN) begin
            if (b == EXIF_TAG[scan_sig_idx]) begin
              scan_sig_idx = scan_sig_idx + 3'd1;
              if (scan_sig_idx == SIG_LEN) begin
                scan_found      = 1'b1;
                scan_tiff_start = {1'b0, idx} + 1;
              end
            end else begin
              scan_sig_idx = SIG_NONE;
            end
          end
          scan_left = scan_left - 16'd1;
          if (scan_left == 16'd0) begin
            if (scan_found) begin
              // short payload after the signature counts as no exif
              tail = {1'b0, idx} - scan_tiff_start + 1;
              if (tail >= MIN_FOUND_SZ) begin
                scan_left = tail[15:0];
                scan_halt(ST_FOUND);
              end else begin
                scan_halt(ST_NO_EXIF);
              end
            end else begin
              scan_phase = PH_MFF;
            end
          end
        end
        default: ;
      endcase
      // a decided verdict waits for the twelfth byte, the final byte forces one
      if (scan_phase == PH_DONE && idx >= SHORT_LAST_IDX) begin
        fire      = 1'b1;
        res       = scan_report(scan_verdict);
        scan_sent = 1'b1;
      end else if (fin) begin
        fire = 1'b1;
        res  = scan_report(idx < SHORT_LAST_IDX ? ST_SHORT :
                           (scan_phase == PH_DONE ? scan_verdict : ST_NO_EXIF));
      end
    end
    if (fin) scan_clear();
    else if (scan_pos != '1) scan_pos = scan_pos + 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 60);
  endfunction

  // offer one byte until the transaction completes, then predict it
  task automatic send_byte(input logic [7:0] b, input logic fin, input bit steady,
                           output logic fire, output jesl_result_t res);
    int gap;
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= fin;
    do @(posedge clk); while (!in_if.ready);
    scan_byte(b, fin, fire, res);
    if (fire) exif_results_due.push_back(res);
    total_bytes++;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // marker segment: FF code len_hi len_lo body; sig_bytes of the body copy the
  // exif signature, with one bit flipped at flip_at when that is in range
  task automatic add_segment(input logic [7:0] code, input int seg_len,
                             input int sig_bytes, input int flip_at);
    logic [7:0] b;
    file_q.push_back(MK_PREFIX);
    file_q.push_back(code);
    file_q.push_back(seg_len[15:8]);
    file_q.push_back(seg_len[7:0]);
    for (int k = 0; k < seg_len - 2; k++) begin
      if (k < sig_bytes) begin
        b = EXIF_TAG[k];
        if (k == flip_at) b = b ^ 8'(1 << $urandom_range(0, 7));
      end else begin
        b = 8'($urandom);
      end
      file_q.push_back(b);
    end
  endtask

  // build one random file into file_q
  task automatic make_file();
    int pick, keep, drop;
    logic [7:0] b;
    logic [7:0] code;
    bit trail;
    file_q.delete();
    trail = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // line noise
      repeat ($urandom_range(1, 24)) file_q.push_back(8'($urandom));
    end else if (pick < 18) begin
      // foreign header: no SOI at the front
      b = 8'($urandom);
      if ($urandom_range(0, 1)) begin
        file_q.push_back(MK_PREFIX);
        if (b == MK_SOI) b = 8'h00;
      end else if (b == MK_PREFIX) begin
        b = 8'h89;
      end
      file_q.push_back(b);
      repeat ($urandom_range(0, 16)) file_q.push_back(8'($urandom));
    end else begin
      file_q.push_back(MK_PREFIX);
      file_q.push_back(MK_SOI);
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 4))
          0: begin
            // standalone marker
            file_q.push_back(MK_PREFIX);
            case ($urandom_range(0, 2))
              0:       file_q.push_back(MK_SOI);
              1:       file_q.push_back(MK_TEM);
              default: file_q.push_back(MK_RST0 + 8'($urandom_range(0, 7)));
            endcase
          end
          1, 2: begin
            code = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                               : PLAIN_CODES[$urandom_range(0, 5)];
            add_segment(code, $urandom_range(2, 10), 0, -1);
          end
          3: add_segment(MK_APP1, $urandom_range(9, 20), 6, $urandom_range(0, 5));
          default: add_segment(MK_APP1, $urandom_range(2, 8), $urandom_range(0, 6), -1);
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_segment(MK_APP1, $urandom_range(16, 40), 6, -1);
        4: add_segment(MK_APP1, $urandom_range(9, 15), 6, -1);  // short payload
        5: begin
          file_q.push_back(MK_PREFIX);
          file_q.push_back($urandom_range(0, 1) ? MK_SOS : MK_EOI);
        end
        6: begin
          // marker without its FF prefix
          b = 8'($urandom);
          if (b == MK_PREFIX) b = 8'h00;
          file_q.push_back(b);
        end
        7: begin
          // length field under two
          code = $urandom_range(0, 1) ? MK_APP1 : PLAIN_CODES[$urandom_range(0, 5)];
          add_segment(code, $urandom_range(0, 1), 0, -1);
        end
        8: begin
          // exif segment cut off by the end of the file
          add_segment(MK_APP1, $urandom_range(16, 40), 6, -1);
          drop = $urandom_range(1, 10);
          file_q = file_q[0:file_q.size()-1-drop];
          trail = 1'b0;
        end
        default: ;
      endcase
      if (trail) repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom));
      // now and then a file under twelve bytes
      if ($urandom_range(0, 9) == 0) begin
        keep = $urandom_range(1, 11);
        if (keep < file_q.size()) file_q = file_q[0:keep-1];
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: compare each transaction against the oldest prediction and
  // pace ready, with one long hold-off so the block backs up into its input
  // ---------------------------------------------------------------------------
  initial begin
    jesl_result_t due;
    int  stall_left;
    int  calm_left;
    int  r;
    bit  long_hold_done;
    out_if.ready   <= 1'b0;
    stall_left     = 0;
    calm_left      = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (exif_results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got status %0d offset %0d size %0d",
                   $time, out_if.status, out_if.payload_offset, out_if.payload_size);
        end else begin
          due = exif_results_due.pop_front();
          results_seen++;
          status_hits[due.status]++;
          if (out_if.status !== due.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, due.status, out_if.status);
          end
          if (out_if.payload_offset !== due.payload_offset) begin
            errors++;
            $display("%0t: payload_offset mismatch, expected %0d, got %0d",
                     $time, due.payload_offset, out_if.payload_offset);
          end
          if (out_if.payload_size !== due.payload_size) begin
            errors++;
            $display("%0t: payload_size mismatch, expected %0d, got %0d",
                     $time, due.payload_size, out_if.payload_size);
          end
        end
      end
      if (!long_hold_done && results_seen >= 12) begin
        stall_left     = 400;
        long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) calm_left = 80;
          else if (r < 30) stall_left = idle_len();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side: reset, directed table, random files, drain
  // ---------------------------------------------------------------------------
  initial begin
    logic         fire;
    jesl_result_t res;
    int           files_done;
    int           random_bytes;
    bit           steady;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= 8'h00;
    in_if.last_byte <= 1'b0;
    errors       = 0;
    results_seen = 0;
    total_bytes  = 0;
    files_done   = 0;
    random_bytes = 0;
    status_hits  = '{0, 0, 0, 0};
    scan_clear();

    dir_rows = '{
      '{8'hff, 1'b1, 1'b1, RES_SHORT},     // one-byte file
      '{8'hff, 1'b0, 1'b0, RES_ANY},       // SOI
      '{8'hd8, 1'b0, 1'b0, RES_ANY},
      '{8'hff, 1'b0, 1'b0, RES_ANY},       // APP1, length 16
      '{8'he1, 1'b0, 1'b0, RES_ANY},
      '{8'h00, 1'b0, 1'b0, RES_ANY},
      '{8'h10, 1'b0, 1'b0, RES_ANY},
      '{8'h45, 1'b0, 1'b0, RES_ANY},       // "Exif" 0 0
      '{8'h78, 1'b0, 1'b0, RES_ANY},
      '{8'h69, 1'b0, 1'b0, RES_ANY},
      '{8'h66, 1'b0, 1'b0, RES_ANY},
      '{8'h00, 1'b0, 1'b0, RES_ANY},
      '{8'h00, 1'b0, 1'b0, RES_ANY},
      '{8'h00, 1'b0, 1'b0, RES_ANY},       // smallest payload that still counts
      '{8'hff, 1'b0, 1'b0, RES_ANY},
      '{8'h80, 1'b0, 1'b0, RES_ANY},
      '{8'h7f, 1'b0, 1'b0, RES_ANY},
      '{8'h01, 1'b0, 1'b0, RES_ANY},
      '{8'hfe, 1'b0, 1'b0, RES_ANY},
      '{8'h55, 1'b0, 1'b0, RES_ANY},
      '{8'haa, 1'b0, 1'b1, RES_MIN_EXIF},  // segment closes: exif found
      '{8'hd9, 1'b1, 1'b0, RES_ANY},       // after the result: ignored
      '{8'h00, 1'b0, 1'b0, RES_ANY},       // garbage, then ends too soon
      '{8'hff, 1'b1, 1'b1, RES_SHORT}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].fin, 1'b0, fire, res);
      if (dir_rows[i].typed && (!fire || res != dir_rows[i].want)) begin
        errors++;
        $display("%0t: directed row %0d, expected status %0d offset %0d size %0d",
                 $time, i, dir_rows[i].want.status, dir_rows[i].want.payload_offset,
                 dir_rows[i].want.payload_size);
        $display("  got %s: status %0d offset %0d size %0d",
                 fire ? "a result" : "no result",
                 res.status, res.payload_offset, res.payload_size);
      end
    end

    while (random_bytes < 630) begin
      if (files_done == 6) begin
        // largest length field a segment allows, file cut off inside its body
        file_q.delete();
        file_q.push_back(MK_PREFIX);
        file_q.push_back(MK_SOI);
        add_segment(MK_APP1, 65535, 6, -1);
        file_q = file_q[0:31];
        steady = 1'b1;
      end else begin
        make_file();
        steady = ($urandom_range(0, 3) == 0);
      end
      random_bytes += file_q.size();
      foreach (file_q[k]) send_byte(file_q[k], k == file_q.size() - 1, steady, fire, res);
      files_done++;
      if (files_done == 12) begin
        // let every outstanding result drain before going on
        in_if.valid <= 1'b0;
        while (exif_results_due.size() != 0) @(posedge clk);
        @(posedge clk);
      end
    end

    in_if.valid <= 1'b0;
    while (exif_results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run: %0d random files plus the directed table, %0d bytes, %0d results checked",
             files_done, total_bytes, results_seen);
    $display("results by status: found %0d, no exif %0d, not jpeg %0d, too short %0d",
             status_hits[ST_FOUND], status_hits[ST_NO_EXIF], status_hits[ST_NOT_JPEG],
             status_hits[ST_SHORT]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
